// ===== rtl/lru_key_value_cache_core_defines.svh =====
// Assertion macros used by the checker file of the cache core.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LKVC_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("cache core assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LKVC_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("cache core assertion failed");

`endif

// ===== rtl/lru_kvc_pkg.sv =====
package lru_kvc_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int AGE_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic {
		FUNC_GET = 1'b0,
		FUNC_SET = 1'b1
	} func_t;

	typedef struct packed {
		func_t                   func;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                    hit;
		logic signed [VAL_W-1:0] read_value;
		logic                    evicted;
		logic signed [KEY_W-1:0] evicted_key;
	} rsp_t;

endpackage

// ===== rtl/lru_key_value_cache_core.sv =====
// Channel   Direction  tdata (low bit up)              tuser (low bit up)
// s_axis    in         key[31:0], value[63:32]         func[0] (0 get, 1 set)
// m_axis    out        read_value[31:0],               hit[0], evicted[1]
//                      evicted_key[63:32]
// cfg       in         cfg_wdata = capacity[4:0], written when cfg_we is high
//
// One transaction is accepted per cycle while results are being taken; a request
// waits in the input register, and its result loads into the output register on
// the edge on which the request advances. The rate is set by the combinational
// parallel key compare and age update across all entries of the store.
// Reset clears the valid marks, ages and fill count and sets capacity to 16;
// no clearing pass is needed. A stalled result holds in the output register
// while the input register keeps the next request, so the input stalls only
// when both are full.
module lru_key_value_cache_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [63:0]                   s_tdata,   // key[31:0], value[63:32]
	input  logic [0:0]                    s_tuser,   // func[0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [63:0]                   m_tdata,   // read_value[31:0], evicted_key[63:32]
	output logic [1:0]                    m_tuser,   // hit[0], evicted[1]
	input  logic                          cfg_we,
	input  logic [lru_kvc_pkg::CAP_W-1:0] cfg_wdata
);
	import lru_kvc_pkg::*;

	logic             valid_s1;
	req_t             req_s1;
	logic             out_valid_q;
	rsp_t             rsp_q;
	rsp_t             rsp_next;
	logic [CAP_W-1:0] cap_q;
	logic             advance;

	// The request in the input register moves on whenever the output register
	// is empty or its result is being taken in this cycle.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.func  <= func_t'(s_tuser[0]);
			req_s1.key   <= s_tdata[31:0];
			req_s1.value <= s_tdata[63:32];
		end
	end

	// The store answers from its current state and commits the update on the
	// same edge that loads the result register, so back-to-back requests on the
	// same key see each other's effect.
	lru_kvc_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd_en   (advance),
		.req      (req_s1),
		.capacity (cap_q),
		.rsp      (rsp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {rsp_q.evicted_key, rsp_q.read_value};
	assign m_tuser  = {rsp_q.evicted, rsp_q.hit};

endmodule

// ===== rtl/lru_kvc_store.sv =====
module lru_kvc_store (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           upd_en,
	input  lru_kvc_pkg::req_t              req,
	input  logic [lru_kvc_pkg::CAP_W-1:0]  capacity,
	output lru_kvc_pkg::rsp_t              rsp
);
	import lru_kvc_pkg::*;

	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [MAX_ENTRIES-1:0] valid_q;
	logic [AGE_W-1:0]       age_q   [MAX_ENTRIES];
	logic [KEY_W-1:0]       key_q   [MAX_ENTRIES];
	logic [VAL_W-1:0]       value_q [MAX_ENTRIES];
	logic [CNT_W-1:0]       used_q;

	logic [MAX_ENTRIES-1:0] hit_vec;
	logic [MAX_ENTRIES-1:0] old_vec;
	logic [MAX_ENTRIES-1:0] age_inc;
	logic                   hit_any;
	logic [IDX_W-1:0]       hit_idx;
	logic [IDX_W-1:0]       free_idx;
	logic [IDX_W-1:0]       old_idx;
	logic [IDX_W-1:0]       slot;
	logic [AGE_W-1:0]       limit;
	logic [CNT_W-1:0]       eff_cap;
	logic [CNT_W-1:0]       used_m1;
	logic [CMP_W-1:0]       cap_ext;
	logic                   promote;
	logic                   fill;
	logic                   wr_key;
	logic                   wr_val;

	function automatic logic [IDX_W-1:0] first_set(input logic [MAX_ENTRIES-1:0] v);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

	// Zero acts as one, anything above the store size saturates.
	always_comb begin
		cap_ext = CMP_W'(capacity);
		if (capacity == '0) begin
			eff_cap = CNT_W'(1);
		end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
			eff_cap = CNT_W'(MAX_ENTRIES);
		end else begin
			eff_cap = CNT_W'(cap_ext);
		end
	end

	// Valid ages always form 0..used-1, so the oldest entry is the one at used-1.
	assign used_m1 = used_q - CNT_W'(1);

	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			hit_vec[i] = valid_q[i] && (key_q[i] == req.key);
			old_vec[i] = valid_q[i] && (CNT_W'(age_q[i]) == used_m1);
		end
	end

	assign hit_any  = |hit_vec;
	assign hit_idx  = first_set(hit_vec);
	assign free_idx = first_set(~valid_q);
	assign old_idx  = first_set(old_vec);

	always_comb begin
		rsp.hit         = 1'b0;
		rsp.read_value  = '1;
		rsp.evicted     = 1'b0;
		rsp.evicted_key = '0;
		slot    = hit_idx;
		promote = 1'b0;
		fill    = 1'b0;
		wr_key  = 1'b0;
		wr_val  = 1'b0;
		priority if (hit_any) begin
			rsp.hit = 1'b1;
			promote = 1'b1;
			if (req.func == FUNC_GET) begin
				rsp.read_value = value_q[hit_idx];
			end else begin
				wr_val = 1'b1;
			end
		end else if (req.func == FUNC_SET && used_q < eff_cap) begin
			slot    = free_idx;
			promote = 1'b1;
			fill    = 1'b1;
			wr_key  = 1'b1;
			wr_val  = 1'b1;
		end else if (req.func == FUNC_SET) begin
			slot            = old_idx;
			promote         = 1'b1;
			wr_key          = 1'b1;
			wr_val          = 1'b1;
			rsp.evicted     = 1'b1;
			rsp.evicted_key = key_q[old_idx];
		end else begin
			// A get that misses leaves the store untouched.
		end
	end

	assign limit = age_q[slot];

	// A new fill ages every other valid entry; hits and evictions age only younger ones.
	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			age_inc[i] = (slot != IDX_W'(i)) && valid_q[i] && (fill || age_q[i] < limit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else if (upd_en && promote) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (slot == IDX_W'(i)) begin
					age_q[i] <= '0;
				end else if (age_inc[i]) begin
					age_q[i] <= age_q[i] + AGE_W'(1);
				end
			end
			if (fill) begin
				valid_q[slot] <= 1'b1;
				used_q        <= used_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_en && wr_key) begin
			key_q[slot] <= req.key;
		end
		if (upd_en && wr_val) begin
			value_q[slot] <= req.value;
		end
	end

endmodule

// ===== rtl/lru_kvc_checker.sv =====
`include "lru_key_value_cache_core_defines.svh"

module lru_kvc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// A result that is not taken stays put.
	`LKVC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// The input only stalls behind a result that is waiting to be taken.
	`LKVC_ASSERT_NOW(a_in_stall, s_tvalid && !s_tready, m_tvalid && !m_tready)

	// An eviction only comes from a set that missed.
	`LKVC_ASSERT_NOW(a_evict_is_miss, m_tvalid && m_tuser[1], !m_tuser[0])

	// An eviction belongs to a set, which never returns a stored value.
	`LKVC_ASSERT_NOW(a_evict_no_read, m_tvalid && m_tuser[1], m_tdata[31:0] == 32'hFFFF_FFFF)

	// Without an eviction the reported key is zero.
	`LKVC_ASSERT_NOW(a_no_evict_key, m_tvalid && !m_tuser[1], m_tdata[63:32] == 32'h0)

endmodule

bind lru_key_value_cache_core lru_kvc_checker u_lru_kvc_checker (.*);
